// ----- hw/rtl/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes of the indexed list store: request and result
// payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } res_t;

endpackage

// ----- hw/rtl/ils_ram.sv -----
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ils_engine.sv -----
// ----------------------------------------------------------------------------
// ils_engine
// Request sequencer: decodes one request, keeps the entry count, and moves
// entries through the RAM one read and one write per cycle to open or close
// a gap.
// ----------------------------------------------------------------------------
module ils_engine #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ils_pkg::req_t in_req,
  output logic          res_valid,
  input  logic          res_ready,
  output ils_pkg::res_t res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DONE
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [AW-1:0]          rptr;
  logic [AW-1:0]          rend;
  logic [AW-1:0]          wptr;
  logic                   pend;
  logic                   dir_up;
  logic [AW-1:0]          put_addr;
  logic [VALUE_WIDTH-1:0] put_val;

  logic                   accept;
  logic [MW-1:0]          pos_m;
  logic [MW-1:0]          cnt_m;
  logic [MW-1:0]          tgt_m;
  logic [VALUE_WIDTH-1:0] val_ext;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign accept    = in_valid && !in_stall;
  assign pos_m     = MW'(in_req.position);
  assign cnt_m     = MW'(count);
  assign val_ext   = VALUE_WIDTH'(in_req.item_value);

  always_comb begin
    case (in_req.mode)
      ils_pkg::MODE_HEAD: tgt_m = '0;
      ils_pkg::MODE_TAIL: tgt_m = cnt_m;
      default:            tgt_m = pos_m;
    endcase
  end

  assign ram_raddr = (state == S_SHIFT) ? rptr : AW'(in_req.position);
  assign ram_we    = ((state == S_SHIFT) && pend) || (state == S_DRAIN) || (state == S_PUT);
  assign ram_waddr = (state == S_PUT) ? put_addr : wptr;
  assign ram_wdata = (state == S_PUT) ? put_val : ram_rdata;

  ils_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.read_value  <= '0;
            res.status      <= ils_pkg::ST_DONE;
            res.entry_count <= ils_pkg::COUNT_W'(count);
            pend            <= 1'b0;
            unique case (in_req.mode) inside
              ils_pkg::MODE_READ: begin
                if (pos_m < cnt_m) begin
                  state <= S_RD_WAIT;
                end else begin
                  res.read_value <= ils_pkg::DATA_W'({VALUE_WIDTH{1'b1}});
                  res.status     <= ils_pkg::ST_RANGE;
                  state          <= S_DONE;
                end
              end
              ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL, ils_pkg::MODE_AT: begin
                if (tgt_m > cnt_m) begin
                  res.status <= ils_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else if (cnt_m == MW'(CAPACITY)) begin
                  res.status <= ils_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  count           <= count + 1'b1;
                  res.entry_count <= ils_pkg::COUNT_W'(count + 1'b1);
                  put_addr        <= AW'(tgt_m);
                  put_val         <= val_ext;
                  dir_up          <= 1'b1;
                  rptr            <= AW'(count - 1'b1);
                  rend            <= AW'(tgt_m);
                  state           <= (tgt_m == cnt_m) ? S_PUT : S_SHIFT;
                end
              end
              ils_pkg::MODE_DELETE: begin
                if (pos_m >= cnt_m) begin
                  res.status <= ils_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  count           <= count - 1'b1;
                  res.entry_count <= ils_pkg::COUNT_W'(count - 1'b1);
                  dir_up          <= 1'b0;
                  rptr            <= AW'(pos_m + 1'b1);
                  rend            <= AW'(cnt_m - 1'b1);
                  state           <= (pos_m == cnt_m - 1'b1) ? S_DONE : S_SHIFT;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res.read_value <= ils_pkg::DATA_W'(ram_rdata);
          state          <= S_DONE;
        end
        S_SHIFT: begin
          pend <= 1'b1;
          wptr <= dir_up ? rptr + 1'b1 : rptr - 1'b1;
          if (rptr == rend) begin
            state <= S_DRAIN;
          end else begin
            rptr <= dir_up ? rptr - 1'b1 : rptr + 1'b1;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= dir_up ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/indexed_list_store_top.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of signed values kept in one RAM, with read, insert and
// delete by position, and an output register toward the result channel.
// ----------------------------------------------------------------------------
// Read and append at the tail move no entries; neither do refused,
// out-of-range and undefined requests or a delete of the last entry. Each
// moved entry takes one RAM read and one write. One request is in work at
// a time; the next is taken once the result enters the output register.
// Reset clears the entry count and control only; RAM is kept.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ils_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output ils_pkg::res_t out_res
);

  logic          res_valid;
  logic          res_ready;
  ils_pkg::res_t res;

  ils_engine #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

// ----- hw/rtl/ils_checker.sv -----
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ils_pkg::res_t out_res
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result dropped or changed");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status == ils_pkg::ST_FULL))
      |-> (out_res.entry_count == ils_pkg::COUNT_W'(CAPACITY)))
    else $error("full status with count below capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (CAPACITY < 128)) |-> (out_res.entry_count <= ils_pkg::COUNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

bind indexed_list_store_top ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

// ----- tb/indexed_list_store_top_test.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store_top_test
// Drives read, insert and delete requests into the indexed list store and
// checks every result against a shadow copy of the list kept in the bench.
// The run starts with directed corner cases and then adds random sequences.
// These sequences fill the list to capacity, drain it, and mix in
// out-of-range and undefined requests. Random stalls are applied on both
// channels during the first two thirds of the requests, none in the last.
// ----------------------------------------------------------------------------
module indexed_list_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP     = ils_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 80;

  logic          clk;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  ils_pkg::req_t in_req    = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ils_pkg::res_t out_res;

  indexed_list_store_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic signed [ils_pkg::DATA_W-1:0] list_mem [LIST_CAP];
  int unsigned                       list_len = 0;

  ils_pkg::req_t request_q [$];
  bit            hold_q [$];
  ils_pkg::res_t result_q [$];

  logic req_taken   = 1'b0;
  int   sent_count  = 0;
  int   total_items = 0;
  int   cycle_count = 0;
  int   err_count   = 0;
  int   tx_idle, rx_idle, phase;
  int   n_read, n_insert, n_delete, n_other, n_full, n_range, n_results;
  int   peak_len    = 0;
  int   gen_len     = 0;

  function automatic ils_pkg::res_t apply_request(input ils_pkg::req_t r);
    ils_pkg::res_t o;
    int unsigned   p;
    int unsigned   dest;
    o        = '0;
    o.status = ils_pkg::ST_DONE;
    p        = r.position;
    case (r.mode) inside
      ils_pkg::MODE_READ: begin
        if (p < list_len) begin
          o.read_value = list_mem[p];
        end else begin
          o.read_value = -1;
          o.status     = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL, ils_pkg::MODE_AT: begin
        if (r.mode == ils_pkg::MODE_HEAD) dest = 0;
        else if (r.mode == ils_pkg::MODE_TAIL) dest = list_len;
        else dest = p;
        if (dest > list_len) begin
          o.status = ils_pkg::ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          o.status = ils_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > dest; i--) list_mem[i] = list_mem[i-1];
          list_mem[dest] = r.item_value;
          list_len++;
        end
      end
      ils_pkg::MODE_DELETE: begin
        if (p >= list_len) begin
          o.status = ils_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    o.entry_count = list_len[ils_pkg::COUNT_W-1:0];
    return o;
  endfunction

  function automatic void add_req(input logic [ils_pkg::MODE_W-1:0] m,
                                  input int unsigned pos,
                                  input logic [ils_pkg::DATA_W-1:0] v, input bit hold);
    ils_pkg::req_t r;
    r.mode       = m;
    r.position   = pos[ils_pkg::POS_W-1:0];
    r.item_value = v;
    request_q.push_back(r);
    hold_q.push_back(hold);
    case (m) inside
      ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL: if (gen_len < LIST_CAP) gen_len++;
      ils_pkg::MODE_AT:     if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
      ils_pkg::MODE_DELETE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  task automatic note_error(input string what, input ils_pkg::res_t want,
                            input ils_pkg::res_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %0s: expected value %0d status %0d count %0d, %0s %0d status %0d count %0d",
               $realtime, what, want.read_value, want.status, want.entry_count,
               "got value", got.read_value, got.status, got.entry_count);
  endtask

  // request side and result side of the checker
  always @(posedge clk) begin
    ils_pkg::res_t want;
    cycle_count++;
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      want = apply_request(in_req);
      result_q.push_back(want);
      case (in_req.mode) inside
        ils_pkg::MODE_READ:                                       n_read++;
        ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL, ils_pkg::MODE_AT: n_insert++;
        ils_pkg::MODE_DELETE:                                     n_delete++;
        default:                                                  n_other++;
      endcase
      if (want.status == ils_pkg::ST_FULL) n_full++;
      if (want.status == ils_pkg::ST_RANGE) n_range++;
      if (int'(want.entry_count) > peak_len) peak_len = int'(want.entry_count);
    end
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        note_error("result with nothing pending", '0, out_res);
      end else begin
        want = result_q.pop_front();
        if (out_res.read_value !== want.read_value || out_res.status !== want.status ||
            out_res.entry_count !== want.entry_count)
          note_error("result mismatch", want, out_res);
      end
    end
  end

  // request driver and result stall
  always @(negedge clk) begin
    phase = (total_items == 0) ? 0 : (sent_count * 3) / total_items;
    case (phase)
      0:       begin tx_idle = 26; rx_idle = 60; end
      1:       begin tx_idle = 60; rx_idle = 26; end
      default: begin tx_idle = 0;  rx_idle = 0;  end
    endcase
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
      if (!in_valid || req_taken) begin
        if (request_q.size() != 0 && !(hold_q[0] && result_q.size() != 0) &&
            $urandom_range(99) >= tx_idle) begin
          in_req   <= request_q.pop_front();
          void'(hold_q.pop_front());
          in_valid <= 1'b1;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic build_directed();
    add_req(ils_pkg::MODE_READ,   0,   32'd0, 1'b0);
    add_req(ils_pkg::MODE_READ,   127, 32'd0, 1'b0);
    add_req(ils_pkg::MODE_DELETE, 0,   32'd0, 1'b0);
    add_req(ils_pkg::MODE_AT,     1,   32'd5, 1'b0);
    add_req(ils_pkg::MODE_AT,     0,   32'h7fff_ffff, 1'b0);
    add_req(ils_pkg::MODE_HEAD,   99,  32'h8000_0000, 1'b0);
    add_req(ils_pkg::MODE_TAIL,   64,  32'hffff_ffff, 1'b0);
    add_req(ils_pkg::MODE_AT,     3,   32'h0000_0000, 1'b0);
    add_req(ils_pkg::MODE_AT,     2,   32'h5555_5555, 1'b0);
    add_req(ils_pkg::MODE_AT,     1,   32'haaaa_aaaa, 1'b0);
    for (int i = 0; i < 6; i++) add_req(ils_pkg::MODE_READ, i, 32'hffff_ffff, 1'b0);
    add_req(ils_pkg::MODE_DELETE, 0,   32'd0, 1'b0);
    add_req(ils_pkg::MODE_DELETE, 4,   32'd0, 1'b0);
    add_req(ils_pkg::MODE_DELETE, 1,   32'd0, 1'b0);
    add_req(3'd5,                 0,   32'd0, 1'b0);
    add_req(3'd6,                 127, 32'hffff_ffff, 1'b0);
    add_req(3'd7,                 64,  32'h1234_5678, 1'b0);
    add_req(ils_pkg::MODE_AT,     127, 32'd9, 1'b0);
    add_req(ils_pkg::MODE_DELETE, 64,  32'd0, 1'b0);
    add_req(ils_pkg::MODE_READ,   2,   32'd0, 1'b0);
  endtask

  task automatic build_random(input int n);
    bit                         grow;
    int                         refusals;
    int                         roll;
    logic [ils_pkg::MODE_W-1:0] m;
    int unsigned                pos;
    logic [ils_pkg::DATA_W-1:0] v;
    grow     = 1'b1;
    refusals = 0;
    for (int k = 0; k < n; k++) begin
      if (grow && gen_len >= LIST_CAP && ++refusals > 3) begin
        grow     = 1'b0;
        refusals = 0;
      end
      if (!grow && gen_len == 0) grow = 1'b1;
      roll = $urandom_range(99);
      v    = $urandom;
      if ($urandom_range(9) == 0)
        case ($urandom_range(3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'hffff_ffff;
          default: v = 32'h0;
        endcase
      if (roll < 8) begin
        m   = ils_pkg::MODE_W'($urandom_range(7));
        pos = $urandom_range(127);
      end else if (roll < 30) begin
        m   = ils_pkg::MODE_READ;
        pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
      end else if (grow) begin
        case ($urandom_range(2))
          0:       m = ils_pkg::MODE_HEAD;
          1:       m = ils_pkg::MODE_TAIL;
          default: m = ils_pkg::MODE_AT;
        endcase
        pos = (m == ils_pkg::MODE_AT) ? $urandom_range(gen_len) : $urandom_range(127);
      end else begin
        m   = ils_pkg::MODE_DELETE;
        pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
      end
      add_req(m, pos, v, (k == 0) || (k == n / 2));
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL indexed_list_store_top");
    $finish;
  end

  initial begin
    build_directed();
    build_random(RANDOM_ITEMS);
    total_items = request_q.size();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (request_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d reads, %0d inserts, %0d deletes, %0d undefined",
             sent_count, n_read, n_insert, n_delete, n_other);
    $display("  %0d refused as full, %0d out of range, peak length %0d, %0d results, %0d errors",
             n_full, n_range, peak_len, n_results, err_count);
    if (err_count == 0) begin
      $display("PASS indexed_list_store_top");
    end else begin
      $display("FAIL indexed_list_store_top");
    end
    $finish;
  end

endmodule
